FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers for the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge out of reset
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// types, codes and microcode program of the three-phase sine pwm generator
// ----------------------------------------------------------------------------
package spwm_pkg;

    localparam int STEP_W = 4;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
    localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

    localparam logic [31:0] PHASE_STEP_RESET = 32'd8589935;
    localparam logic [15:0] AMPLITUDE_RESET  = 16'd58982;
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd4249;
    localparam logic [15:0] SINE_PEAK        = 16'd32767;

    // phase selectors
    localparam logic [1:0] SEL_U = 2'd0;
    localparam logic [1:0] SEL_V = 2'd1;
    localparam logic [1:0] SEL_W = 2'd2;

    // jump conditions: when true the sequencer goes to the target step
    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_NO_TICK  = 2'd1;
    localparam logic [1:0] COND_OUT_BUSY = 2'd2;

    // program addresses
    localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
    localparam logic [STEP_W-1:0] ST_ISSUE_U = 4'd1;
    localparam logic [STEP_W-1:0] ST_ISSUE_V = 4'd2;
    localparam logic [STEP_W-1:0] ST_ISSUE_W = 4'd3;
    localparam logic [STEP_W-1:0] ST_DRAIN_0 = 4'd4;
    localparam logic [STEP_W-1:0] ST_DRAIN_1 = 4'd5;
    localparam logic [STEP_W-1:0] ST_DRAIN_2 = 4'd6;
    localparam logic [STEP_W-1:0] ST_DRAIN_3 = 4'd7;
    localparam logic [STEP_W-1:0] ST_PUSH    = 4'd8;

    typedef struct packed {
        logic              in_ready;
        logic              issue;
        logic [1:0]        sel;
        logic              out_load;
        logic              last;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic tick;
        logic out_busy;
    } t_useq_stat;

    localparam t_uword UW_NOP = '{
        in_ready: 1'b0, issue: 1'b0, sel: SEL_U, out_load: 1'b0,
        last: 1'b0, cond: COND_NONE, target: ST_WAIT
    };

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] step);
        t_uword uw;
        uw = UW_NOP;
        case (step)
            ST_WAIT: begin
                uw.in_ready = 1'b1;
                uw.cond     = COND_NO_TICK;
                uw.target   = ST_WAIT;
            end
            ST_ISSUE_U: begin
                uw.issue = 1'b1;
                uw.sel   = SEL_U;
            end
            ST_ISSUE_V: begin
                uw.issue = 1'b1;
                uw.sel   = SEL_V;
            end
            ST_ISSUE_W: begin
                uw.issue = 1'b1;
                uw.sel   = SEL_W;
            end
            ST_DRAIN_0, ST_DRAIN_1, ST_DRAIN_2, ST_DRAIN_3: begin
                uw = UW_NOP;
            end
            ST_PUSH: begin
                uw.out_load = 1'b1;
                uw.last     = 1'b1;
                uw.cond     = COND_OUT_BUSY;
                uw.target   = ST_PUSH;
            end
            default: begin
                uw.last = 1'b1;
            end
        endcase
        return uw;
    endfunction

endpackage

FILE: design/spwm_useq.sv
// ----------------------------------------------------------------------------
// spwm_useq
// microcode sequencer: step counter, control word rom and conditional jumps
// ----------------------------------------------------------------------------
module spwm_useq
    import spwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_useq_stat i_stat,
    output t_uword     o_uword
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              jump;

    assign uw = f_ucode(r_step);

    always_comb begin
        case (uw.cond)
            COND_NO_TICK:  jump = !i_stat.tick;
            COND_OUT_BUSY: jump = i_stat.out_busy;
            default:       jump = 1'b0;
        endcase
        if (jump) begin
            n_step = uw.target;
        end else if (uw.last) begin
            n_step = ST_WAIT;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;

endmodule

FILE: design/three_phase_sine_pwm_generator.sv
// an accepted tick starts the microcode program, which feeds the three phases one
// after another through a single rom port and multiplier pair, drains the pipeline
// and pushes the result, waiting while the output is busy; no tick is taken meanwhile
// polls without a tick are taken while waiting and give no result
// reset (synchronous, active low) clears the phase, the control, the valid flags and
// the configuration to their default values; no clearing pass is needed
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_generator
// open-loop three-phase sine pwm duty generator driven by a microcoded sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_phase_sine_pwm_generator
    import spwm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32,
    parameter int DUTY_BITS        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] ms_elapsed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,      // duty_u, duty_v, duty_w, phase_now
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QBITS    = PHASE_BITS - 2;
    localparam int SCALE_W  = QBITS + IDX_BITS;
    localparam logic [63:0] TURN      = 64'd1 << PHASE_BITS;
    localparam logic [63:0] OFF120    = (TURN + 64'd1) / 64'd3;
    localparam logic [63:0] OFF240    = (64'd2 * TURN + 64'd1) / 64'd3;
    localparam logic [63:0] SUB120_64 = TURN - OFF120;
    localparam logic [63:0] SUB240_64 = TURN - OFF240;
    localparam logic [PHASE_BITS-1:0] SUB120 = SUB120_64[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] SUB240 = SUB240_64[PHASE_BITS-1:0];
    localparam logic [31:0] DUTY_MAX_32 = (32'd1 << DUTY_BITS) - 32'd1;
    localparam logic [15:0] DUTY_MAX    = DUTY_MAX_32[15:0];
    localparam logic [63:0]         DEPTH_64    = 64'(SINE_TABLE_DEPTH);
    localparam logic [SCALE_W-1:0]  DEPTH_SCALE = DEPTH_64[SCALE_W-1:0];
    localparam logic [IDX_BITS-1:0] DEPTH_IDX   = DEPTH_64[IDX_BITS-1:0];

    typedef logic [15:0] t_rom [SINE_TABLE_DEPTH];

    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] s;
        int          k;
        int          i;
        for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
            x  = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            for (i = 0; i < 5; i++) begin
                q = (x2 * t) >> 30;
                case (i)
                    0:       q = q / 64'd110;
                    1:       q = q / 64'd72;
                    2:       q = q / 64'd42;
                    3:       q = q / 64'd20;
                    default: q = q / 64'd6;
                endcase
                t = 64'd1073741824 - q;
            end
            s = (x * t) >> 30;
            s = (s * 64'd32767 + 64'd536870912) >> 30;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            rom[k] = s[15:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    // configuration
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [15:0]           r_amp;
    logic [15:0]           r_period;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RESET[PHASE_BITS-1:0];
            r_amp        <= AMPLITUDE_RESET;
            r_period     <= PWM_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_BITS-1:0];
                REG_AMPLITUDE:  r_amp        <= i_cfg_data[15:0];
                REG_PWM_PERIOD: r_period     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    t_uword     uw;
    t_useq_stat stat;
    logic       tick;
    logic       out_free;
    logic       out_load;

    assign s_tready = uw.in_ready;
    assign tick     = s_tvalid & uw.in_ready & s_tdata[0];
    assign out_free = !m_tvalid || m_tready;
    assign out_load = uw.out_load & out_free;
    assign stat     = '{tick: tick, out_busy: !out_free};

    spwm_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    // phase accumulator
    logic [PHASE_BITS-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (tick) begin
            r_acc <= r_acc + r_phase_step;
        end
    end

    // stage a: phase offset, quadrant fold, rom read
    logic [PHASE_BITS-1:0] a_off;
    logic [PHASE_BITS-1:0] a_phase;
    logic [SCALE_W-1:0]    a_scaled;
    logic [IDX_BITS-1:0]   a_idx;
    logic [IDX_BITS-1:0]   a_addr;
    logic                  a_peak;
    logic [15:0]           r_rom_q;
    logic                  r_a_neg;
    logic                  r_a_peak;
    logic                  r_a_v;
    logic [1:0]            r_a_sel;

    always_comb begin
        case (uw.sel)
            SEL_V:   a_off = SUB120;
            SEL_W:   a_off = SUB240;
            default: a_off = '0;
        endcase
        a_phase  = r_acc + a_off;
        a_scaled = {{IDX_BITS{1'b0}}, a_phase[QBITS-1:0]} * DEPTH_SCALE;
        a_idx    = a_scaled[QBITS +: IDX_BITS];
        if (a_phase[PHASE_BITS-2]) begin
            a_peak = (a_idx == '0);
            a_addr = a_peak ? '0 : DEPTH_IDX - a_idx;
        end else begin
            a_addr = a_idx;
            a_peak = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q  <= SINE_ROM[a_addr];
        r_a_neg  <= a_phase[PHASE_BITS-1];
        r_a_peak <= a_peak;
        r_a_sel  <= uw.sel;
    end

    // stage b: signed sine times amplitude
    logic [15:0]        b_mag;
    logic signed [16:0] b_sine;
    logic signed [33:0] b_mul;
    logic [31:0]        r_b_prod;
    logic               r_b_v;
    logic [1:0]         r_b_sel;

    always_comb begin
        b_mag  = r_a_peak ? SINE_PEAK : r_rom_q;
        b_sine = r_a_neg ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
        b_mul  = b_sine * $signed({1'b0, r_amp});
    end

    always_ff @(posedge i_clk) begin
        r_b_prod <= b_mul[31:0];
        r_b_sel  <= r_a_sel;
    end

    // stage c: offset to unsigned
    logic [31:0] r_c_num;
    logic        r_c_v;
    logic [1:0]  r_c_sel;

    always_ff @(posedge i_clk) begin
        r_c_num <= 32'h8000_0000 + r_b_prod;
        r_c_sel <= r_b_sel;
    end

    // stage d: scale by period
    logic [47:0] d_mul;
    logic [47:0] r_d_prod;
    logic        r_d_v;
    logic [1:0]  r_d_sel;

    assign d_mul = 48'(r_c_num) * 48'(r_period);

    always_ff @(posedge i_clk) begin
        r_d_prod <= d_mul;
        r_d_sel  <= r_c_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= uw.issue;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    // stage e: saturate and store
    logic [15:0] e_duty;
    logic [15:0] r_duty_u;
    logic [15:0] r_duty_v;
    logic [15:0] r_duty_w;

    always_comb begin
        e_duty = r_d_prod[47:32];
        if (e_duty > r_period) begin
            e_duty = r_period;
        end
        if (e_duty > DUTY_MAX) begin
            e_duty = DUTY_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_v) begin
            case (r_d_sel)
                SEL_U:   r_duty_u <= e_duty;
                SEL_V:   r_duty_v <= e_duty;
                default: r_duty_w <= e_duty;
            endcase
        end
    end

    // output register
    logic        r_m_tvalid;
    logic [79:0] r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {32'(r_acc), r_duty_w, r_duty_v, r_duty_u};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // checks
    `ASSERT_CLK_RST(a_tick_leaves_wait, i_clk, i_rst_n, tick |=> !s_tready, "sequencer stayed in wait after a tick")
    `ASSERT_CLK_RST(a_acc_only_on_tick, i_clk, i_rst_n, !tick |=> $stable(r_acc), "phase moved without a tick")
    `ASSERT_CLK(a_uword_exclusive, i_clk, $onehot0({uw.in_ready, uw.issue, uw.out_load}), "control word drives more than one action")

endmodule

FILE: tb/three_phase_sine_pwm_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_generator_tb
// drives millisecond ticks and polls into the generator under random source
// and sink stalls and rewrites the phase step, amplitude and period between
// runs. a tracker class rebuilds the quarter-wave table, follows the phase
// and predicts the three duties of every tick, then checks each output
// transaction field by field in order.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_generator_tb
    import spwm_pkg::*;
();

    localparam int          ROM_DEPTH   = 1024;
    localparam int          RUN_CHUNKS  = 9;
    localparam int          CHUNK_TICKS = 162;
    localparam int          CYCLE_LIMIT = 900000;
    localparam int          SETTLE_CYCLES = 12;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    // one third and two thirds of a turn, rounded to nearest
    localparam logic [31:0] LAG_120 = 32'd1431655765;
    localparam logic [31:0] LAG_240 = 32'd2863311531;

    typedef struct packed {
        logic [31:0] phase;
        logic [15:0] duty_w;
        logic [15:0] duty_v;
        logic [15:0] duty_u;
    } t_duty_set;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;       // [0] ms_elapsed
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;       // duty_u, duty_v, duty_w, phase_now
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int send_idle;
    int recv_idle;
    int cycle_count;

    class duty_tracker;
        int          sine_rom[ROM_DEPTH];
        logic [31:0] phase;
        logic [31:0] phase_step;
        logic [15:0] amplitude;
        logic [15:0] period;
        t_duty_set   pending_duties[$];
        int          errors;

        function new();
            longint unsigned x, x2, t, sv;
            longint unsigned divs[5];
            divs = '{110, 72, 42, 20, 6};
            for (int k = 0; k < ROM_DEPTH; k++) begin
                x  = (Q30_HALF_PI * longint'(k)) / ROM_DEPTH;
                x2 = (x * x) >> 30;
                t  = Q30_ONE;
                for (int i = 0; i < 5; i++) begin
                    t = Q30_ONE - ((x2 * t) >> 30) / divs[i];
                end
                sv = (x * t) >> 30;
                sv = (sv * SINE_PEAK + (Q30_ONE >> 1)) >> 30;
                if (sv > SINE_PEAK) begin
                    sv = SINE_PEAK;
                end
                sine_rom[k] = int'(sv);
            end
            phase      = '0;
            phase_step = PHASE_STEP_RESET;
            amplitude  = AMPLITUDE_RESET;
            period     = PWM_PERIOD_RESET;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(input logic [1:0] index, input logic [31:0] data);
            case (index)
                REG_PHASE_STEP: phase_step = data;
                REG_AMPLITUDE:  amplitude  = data[15:0];
                REG_PWM_PERIOD: period     = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] predict_duty(input logic [31:0] p);
            longint          s;
            longint          num;
            longint unsigned d;
            // mirrored read in odd quadrants, one past the end is the peak
            if (p[30]) begin
                if (p[29:20] == '0) begin
                    s = longint'(SINE_PEAK);
                end else begin
                    s = sine_rom[ROM_DEPTH - int'(p[29:20])];
                end
            end else begin
                s = sine_rom[p[29:20]];
            end
            if (p[31]) begin
                s = -s;
            end
            num = 64'sd2147483648 + s * longint'(amplitude);
            d   = (unsigned'(num) * period) >> 32;
            if (d > period) begin
                d = period;
            end
            return d[15:0];
        endfunction

        function void note_tick(input logic ms_elapsed);
            t_duty_set ds;
            if (ms_elapsed) begin
                phase     = phase + phase_step;
                ds.phase  = phase;
                ds.duty_u = predict_duty(phase);
                ds.duty_v = predict_duty(phase - LAG_120);
                ds.duty_w = predict_duty(phase - LAG_240);
                pending_duties.push_back(ds);
            end
        endfunction

        task check_duties(input logic [79:0] data);
            t_duty_set got;
            t_duty_set want;
            got = data;
            if (pending_duties.size() == 0) begin
                report($sformatf("unexpected result %h", data));
            end else begin
                want = pending_duties.pop_front();
                if (got.duty_u !== want.duty_u)
                    report($sformatf("duty_u got %0d expected %0d", got.duty_u, want.duty_u));
                if (got.duty_v !== want.duty_v)
                    report($sformatf("duty_v got %0d expected %0d", got.duty_v, want.duty_v));
                if (got.duty_w !== want.duty_w)
                    report($sformatf("duty_w got %0d expected %0d", got.duty_w, want.duty_w));
                if (got.phase !== want.phase)
                    report($sformatf("phase_now got %h expected %h", got.phase, want.phase));
            end
        endtask

        function int pending();
            return pending_duties.size();
        endfunction
    endclass

    duty_tracker sb;

    three_phase_sine_pwm_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sink side with random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                sb.check_duties(m_tdata);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_tick(input logic ms_elapsed);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, ms_elapsed};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        sb.note_tick(ms_elapsed);
    endtask

    // source stays quiet until every result is out, then waits out a settling delay
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] step, input logic [15:0] amp,
                              input logic [15:0] per);
        logic [31:0] vals[3];
        logic [1:0]  idxs[3];
        vals = '{step, {16'b0, amp}, {16'b0, per}};
        idxs = '{REG_PHASE_STEP, REG_AMPLITUDE, REG_PWM_PERIOD};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            sb.set_reg(idxs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] step;
        logic [15:0] amp;
        logic [15:0] per;
        int          ticks;
        int          drain;
        logic        ms;

        sb          = new();
        cycle_count = 0;
        send_idle   = 0;
        recv_idle   = 0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_PHASE_STEP;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, polls around ticks
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        // land on zero, then step by quarter turns over the quadrant edges
        settle();
        write_regs(32'd0 - sb.phase, 16'hFFFF, 16'hFFFF);
        send_tick(1'b1);
        settle();
        write_regs(32'h4000_0000, 16'hFFFF, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        // zero period
        settle();
        write_regs(32'h4000_0000, 16'd62259, 16'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        // no step, no amplitude, smallest period
        settle();
        write_regs(32'd0, 16'd0, 16'd1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        // largest step
        settle();
        write_regs(32'hFFFF_FFFF, 16'hFFFF, 16'd1);
        send_tick(1'b1);
        send_tick(1'b1);

        for (int c = 0; c < RUN_CHUNKS; c++) begin
            settle();
            case (c / 3)
                0: begin send_idle = 35; recv_idle = 87; end
                1: begin send_idle = 87; recv_idle = 35; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            step = $urandom();
            amp  = 16'($urandom_range(0, 65535));
            per  = 16'($urandom_range(1, 65535));
            case (c)
                0: begin
                    step = PHASE_STEP_RESET;
                    amp  = AMPLITUDE_RESET;
                    per  = PWM_PERIOD_RESET;
                end
                1: begin amp = 16'd62259; per = 16'hFFFF; end
                3: amp = 16'hFFFF;
                4: per = 16'($urandom_range(1, 16));
                6: step = $urandom_range(1, 32'h0010_0000);
                default: ;
            endcase
            write_regs(step, amp, per);
            ticks = 0;
            while (ticks < CHUNK_TICKS) begin
                ms = ($urandom_range(0, 3) != 0);
                send_tick(ms);
                if (ms) begin
                    ticks++;
                end
            end
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
